[rtl/frls_pkg.sv]
// ----------------------------------------------------------------------------
// frls_pkg
// Shared constants and types for the flash record log store.
// ----------------------------------------------------------------------------
package frls_pkg;

    localparam int AREA_BYTES = 256;
    localparam int MAX_RECORD = 64;
    localparam int LEN_MAX    = (MAX_RECORD < AREA_BYTES) ? MAX_RECORD : AREA_BYTES;

    localparam int ADDR_W = $clog2(AREA_BYTES);
    localparam int IDX_W  = $clog2(MAX_RECORD);
    localparam int SUM_W  = ADDR_W + 2;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [6:0] REC_LEN_RESET = 7'd16;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN_A    = 7'b0000010,
        ST_SCAN_B    = 7'b0000100,
        ST_SCAN_C    = 7'b0001000,
        ST_EMIT_RD   = 7'b0010000,
        ST_EMIT_LD   = 7'b0100000,
        ST_EMIT_WAIT = 7'b1000000
    } frls_state_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } frls_func_t;

endpackage

[rtl/flash_record_log_store_unit.sv]
// ----------------------------------------------------------------------------
// flash_record_log_store_unit
// Wear-levelling record log in a byte store: stages write bytes, commits a
// record into the first empty slot (erasing the store when full) and reads
// back the newest record one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  | signals                               | flow
//  ---------+---------------------------------------+------------------------
//  req      | req_valid req_ready func data_byte    | in, valid/ready
//           | last_byte                             |
//  rsp      | rsp_valid rsp_ready read_byte         | out, valid/ready
//           | byte_index is_last area_erased        |
//  cfg      | cfg_we cfg_data                       | in, write only
//
//  a staged write byte without last_byte is staged and the unit stays idle
//  a commit or read scans slot by slot through the single store read port,
//  in states SCAN_A, SCAN_B and SCAN_C per slot, then emits each record byte
//  through EMIT_RD, EMIT_LD and EMIT_WAIT, held there by any output stall
//  req_ready is low from a commit or read until its last byte is taken
//  reset marks every store byte erased at once through per-byte valid bits
// ----------------------------------------------------------------------------
module flash_record_log_store_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [7:0]  read_byte,
    output logic [5:0]  byte_index,
    output logic        is_last,
    output logic        area_erased
);
    import frls_pkg::*;

    // control state
    frls_state_t              state_reg, state_next;
    logic [6:0]               rec_len_reg;
    logic [6:0]               staged_cnt_reg, staged_cnt_next;
    logic [ADDR_W:0]          scan_reg, scan_next;
    logic [ADDR_W:0]          whole_reg, whole_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic                     is_wr_reg, is_wr_next;
    logic                     first_ff_reg, first_ff_next;
    logic                     erased_reg, erased_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [AREA_BYTES-1:0]    vld_reg;
    logic                     rd_vld_reg;

    // memories and payload
    logic [7:0]               store_mem [AREA_BYTES];
    logic [7:0]               stg_mem [MAX_RECORD];
    logic [7:0]               store_q_reg;
    logic [7:0]               stg_q_reg;
    logic [7:0]               read_byte_reg;
    logic [5:0]               byte_index_reg;
    logic                     is_last_reg;

    logic [6:0]               len;
    logic [SUM_W-1:0]         len_w, scan_ext, scan_nx_ext, emit_addr_ext;
    logic [ADDR_W-1:0]        st_raddr, emit_addr;
    logic                     st_we, stg_we, vld_clear;
    logic [7:0]               st_byte;
    logic                     slot_empty, rec_last;

    // effective record length, saturated to 1..LEN_MAX
    always_comb
    begin
        if (rec_len_reg == 7'd0)
            len = 7'd1;
        else if (rec_len_reg > 7'(LEN_MAX))
            len = 7'(LEN_MAX);
        else
            len = rec_len_reg;
    end

    assign len_w         = SUM_W'(len);
    assign scan_ext      = SUM_W'(scan_reg);
    assign scan_nx_ext   = scan_ext + len_w;
    assign emit_addr_ext = SUM_W'(base_reg) + SUM_W'(k_reg);
    assign emit_addr     = emit_addr_ext[ADDR_W-1:0];
    assign st_byte       = rd_vld_reg ? store_q_reg : ERASED_BYTE;
    assign slot_empty    = first_ff_reg && (st_byte == ERASED_BYTE);
    assign rec_last      = ((7'(k_reg) + 7'd1) == len);

    assign req_ready = (state_reg == ST_IDLE);
    assign st_we     = (state_reg == ST_EMIT_LD) && is_wr_reg;
    assign stg_we    = req_valid && req_ready && (func == FUNC_WRITE)
                       && (staged_cnt_reg < 7'(MAX_RECORD));

    always_comb
    begin
        unique case (state_reg)
            ST_SCAN_B:  st_raddr = ADDR_W'(scan_ext + SUM_W'(1));
            ST_EMIT_RD: st_raddr = emit_addr;
            default:    st_raddr = scan_reg[ADDR_W-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        staged_cnt_next = staged_cnt_reg;
        scan_next       = scan_reg;
        whole_next      = whole_reg;
        base_next       = base_reg;
        k_next          = k_reg;
        is_wr_next      = is_wr_reg;
        first_ff_next   = first_ff_reg;
        erased_next     = erased_reg;
        rsp_valid_next  = rsp_valid_reg;
        vld_clear       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    scan_next   = '0;
                    whole_next  = '0;
                    erased_next = 1'b0;
                    if (func == FUNC_READ)
                    begin
                        is_wr_next = 1'b0;
                        state_next = ST_SCAN_A;
                    end
                    else
                    begin
                        is_wr_next = 1'b1;
                        if (stg_we)
                            staged_cnt_next = staged_cnt_reg + 7'd1;
                        if (last_byte)
                            state_next = ST_SCAN_A;
                    end
                end
            end
            ST_SCAN_A:
                state_next = ST_SCAN_B;
            ST_SCAN_B:
            begin
                first_ff_next = (st_byte == ERASED_BYTE);
                state_next    = ST_SCAN_C;
            end
            ST_SCAN_C:
            begin
                if (!slot_empty && (scan_nx_ext + SUM_W'(1) < SUM_W'(AREA_BYTES)))
                begin
                    // step to the next slot, keep track of the last whole one
                    scan_next = scan_nx_ext[ADDR_W:0];
                    if (scan_nx_ext + len_w <= SUM_W'(AREA_BYTES))
                        whole_next = scan_nx_ext[ADDR_W:0];
                    state_next = ST_SCAN_A;
                end
                else
                begin
                    if (!slot_empty && (scan_nx_ext + len_w <= SUM_W'(AREA_BYTES)))
                        whole_next = scan_nx_ext[ADDR_W:0];
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                    if (!is_wr_reg)
                    begin
                        if (!slot_empty)
                            base_next = whole_next[ADDR_W-1:0];
                        else if (scan_reg == '0)
                            base_next = '0;
                        else
                            base_next = ADDR_W'(scan_ext - len_w);
                    end
                    else
                    begin
                        staged_cnt_next = '0;
                        if (!slot_empty || (scan_nx_ext > SUM_W'(AREA_BYTES)))
                        begin
                            vld_clear   = 1'b1;
                            erased_next = 1'b1;
                            base_next   = '0;
                        end
                        else
                            base_next = scan_reg[ADDR_W-1:0];
                    end
                end
            end
            ST_EMIT_RD:
                state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    if (is_last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rec_len_reg    <= REC_LEN_RESET;
            staged_cnt_reg <= '0;
            scan_reg       <= '0;
            whole_reg      <= '0;
            base_reg       <= '0;
            k_reg          <= '0;
            is_wr_reg      <= 1'b0;
            first_ff_reg   <= 1'b0;
            erased_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            staged_cnt_reg <= staged_cnt_next;
            scan_reg       <= scan_next;
            whole_reg      <= whole_next;
            base_reg       <= base_next;
            k_reg          <= k_next;
            is_wr_reg      <= is_wr_next;
            first_ff_reg   <= first_ff_next;
            erased_reg     <= erased_next;
            rsp_valid_reg  <= rsp_valid_next;
            rd_vld_reg     <= vld_reg[st_raddr];
            if (cfg_we)
                rec_len_reg <= cfg_data;
            // erase drops every valid bit at once
            if (vld_clear)
                vld_reg <= '0;
            else if (st_we)
                vld_reg[emit_addr] <= 1'b1;
        end
    end

    // byte store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[emit_addr] <= stg_q_reg;
        store_q_reg <= store_mem[st_raddr];
    end

    // staging buffer
    always_ff @(posedge clk)
    begin
        if (stg_we)
            stg_mem[staged_cnt_reg[IDX_W-1:0]] <= data_byte;
        stg_q_reg <= stg_mem[k_reg];
    end

    // output register, a commit returns what it has just written
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT_LD)
        begin
            read_byte_reg  <= is_wr_reg ? stg_q_reg : st_byte;
            byte_index_reg <= 6'(k_reg);
            is_last_reg    <= rec_last;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_byte   = read_byte_reg;
    assign byte_index  = byte_index_reg;
    assign is_last     = is_last_reg;
    assign area_erased = erased_reg;

endmodule
